/* rtl/imu_frame_deframer_scaler_unit_assert.svh */
// Assertion macros for the IMU frame deframer/scaler.
// Used by imu_frame_deframer_scaler_unit; expects clk and rst_n in scope.
`ifndef IMU_FRAME_DEFRAMER_SCALER_UNIT_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_SCALER_UNIT_ASSERT_SVH

// checked only out of reset
`define IFDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IFDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ifds_pkg.sv */
// Shared types and constants for the IMU frame deframer/scaler.
// No dependencies.
package ifds_pkg;

    localparam int FRAME_LEN  = 22;
    localparam int WORD_COUNT = 10;
    localparam int FILL_W     = 5;
    localparam int STEP_W     = 4;
    localparam int PROD_W     = 49;

    localparam logic [7:0]  HEADER_BYTE = 8'h55;
    localparam logic [FILL_W-1:0] FILL_LAST = 5'd21;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;
    localparam logic [STEP_W-1:0] STEP_GYRO = 4'd3;
    localparam logic [STEP_W-1:0] STEP_QUAT = 4'd6;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 49'sd8388608;

    localparam logic [31:0] ACCEL_COEFF_RST = 32'd1316226280;
    localparam logic [31:0] GYRO_COEFF_RST  = 32'd292817730;
    localparam logic [31:0] QUAT_COEFF_RST  = 32'd109951163;

    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_GYRO  = 2'd1;
    localparam logic [1:0] REG_QUAT  = 2'd2;

    typedef logic [WORD_COUNT-1:0][31:0] word_vec_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic mul;
        logic acc;
        logic restore;
        logic drop;
        logic load_out;
    } ifds_cmd_t;

    typedef struct packed {
        logic fill_one;
        logic fill_last;
        logic hdr_next;
        logic step_last;
        logic sum_ok;
    } ifds_status_t;

endpackage

/* rtl/ifds_ctrl.sv */
// Sequencer for the IMU frame deframer/scaler.
// Depends on ifds_pkg; drives the command struct of ifds_dp.
module ifds_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  ifds_pkg::ifds_status_t status,
    output ifds_pkg::ifds_cmd_t   cmd
);
    import ifds_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL     = 3'd1;
    localparam logic [2:0] ST_ACC     = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_PUBLISH = 3'd4;
    localparam logic [2:0] ST_RESTORE = 3'd5;
    localparam logic [2:0] ST_SHIFT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.fill_last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.step_last ? ST_CHECK : ST_MUL;
            end
            ST_CHECK:
            begin
                state_next = status.sum_ok ? ST_PUBLISH : ST_RESTORE;
            end
            ST_PUBLISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RESTORE:
            begin
                cmd.restore = 1'b1;
                state_next  = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.drop = 1'b1;
                if (status.fill_one || status.hdr_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/ifds_dp.sv */
// Datapath for the IMU frame deframer/scaler: byte window, checksum,
// shared multiplier, staging and output words. Depends on ifds_pkg.
module ifds_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            rx_byte,
    input  logic [31:0]           accel_coeff,
    input  logic [31:0]           gyro_coeff,
    input  logic [31:0]           quat_coeff,
    input  ifds_pkg::ifds_cmd_t   cmd,
    output ifds_pkg::ifds_status_t status,
    output ifds_pkg::word_vec_t   out_word
);
    import ifds_pkg::*;

    logic [7:0]              win_reg  [FRAME_LEN];
    logic [7:0]              win_next [FRAME_LEN];
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic [STEP_W-1:0]       step_reg;
    logic [7:0]              sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] rnd;
    logic signed [15:0]      raw;
    logic [31:0]             coeff;
    logic [31:0]             scaled;
    word_vec_t               stage_reg;
    word_vec_t               out_reg;
    logic                    keep_byte;

    assign keep_byte = (fill_reg != '0) || (rx_byte == HEADER_BYTE);

    assign status.fill_one  = (fill_reg == 5'd1);
    assign status.fill_last = (fill_reg == FILL_LAST);
    assign status.hdr_next  = (win_reg[1] == HEADER_BYTE);
    assign status.step_last = (step_reg == STEP_LAST);
    assign status.sum_ok    = (sum_reg == win_reg[1]);

    assign raw = $signed({win_reg[2], win_reg[1]});

    always_comb
    begin
        if (step_reg < STEP_GYRO)
            coeff = accel_coeff;
        else if (step_reg < STEP_QUAT)
            coeff = gyro_coeff;
        else
            coeff = quat_coeff;
    end

    assign prod_next = PROD_W'(raw) * PROD_W'($signed({1'b0, coeff}));
    assign rnd       = prod_reg + ROUND_BIAS;
    assign scaled    = {{7{rnd[PROD_W-1]}}, rnd[PROD_W-1:24]};

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (cmd.accept && keep_byte)
        begin
            win_next[fill_reg] = rx_byte;
            fill_next          = fill_reg + 5'd1;
        end
        if (cmd.acc || cmd.restore)
        begin
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                win_next[i] = win_reg[(i + 2) % FRAME_LEN];
            end
        end
        if (cmd.drop)
        begin
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            fill_next = fill_reg - 5'd1;
        end
        if (cmd.load_out)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.start)
                step_reg <= '0;
            else if (cmd.acc)
                step_reg <= step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (cmd.start)
            sum_reg <= '0;
        else if (cmd.mul)
            sum_reg <= sum_reg + win_reg[1] + win_reg[2];
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.acc)
            stage_reg[step_reg] <= scaled;
        if (cmd.load_out)
            out_reg <= stage_reg;
    end

    assign out_word = out_reg;

endmodule

/* rtl/imu_frame_deframer_scaler_unit.sv */
// Top level of the IMU frame deframer/scaler: APB register file plus
// controller and datapath. Depends on ifds_pkg, ifds_ctrl, ifds_dp.
//
// Takes one UART byte per request, accepted while no frame is being
// processed. Bytes before a 0x55 header are dropped; a 22-byte frame
// (header, 20 payload bytes, 8-bit additive checksum) is collected.
// After the last byte the ten int16 words go through one shared 16x33
// multiplier (a multiply then an accumulate state per word); a good frame
// is then checked and published (plus any wait for a held result to be
// taken). A bad checksum restores the window and drops bytes (at most 22)
// while resyncing to the next buffered 0x55. Each word is signed Q15.16:
// (raw*coeff+2^23)>>24; coefficients at 0x0 (accel), 0x4 (gyro), 0x8 (quat).
module imu_frame_deframer_scaler_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic signed [31:0] rate_x,
    output logic signed [31:0] rate_y,
    output logic signed [31:0] rate_z,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z
);
    import ifds_pkg::*;

    logic [31:0]  accel_coeff_reg;
    logic [31:0]  gyro_coeff_reg;
    logic [31:0]  quat_coeff_reg;
    logic         reg_wr;
    logic [1:0]   reg_idx;
    ifds_cmd_t    cmd;
    ifds_status_t status;
    word_vec_t    out_word;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_coeff_reg <= ACCEL_COEFF_RST;
            gyro_coeff_reg  <= GYRO_COEFF_RST;
            quat_coeff_reg  <= QUAT_COEFF_RST;
        end
        else if (reg_wr)
        begin
            case (reg_idx)
                REG_ACCEL: accel_coeff_reg <= pwdata;
                REG_GYRO:  gyro_coeff_reg  <= pwdata;
                REG_QUAT:  quat_coeff_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACCEL: prdata = accel_coeff_reg;
            REG_GYRO:  prdata = gyro_coeff_reg;
            REG_QUAT:  prdata = quat_coeff_reg;
            default:   prdata = '0;
        endcase
    end

    ifds_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ifds_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .accel_coeff (accel_coeff_reg),
        .gyro_coeff  (gyro_coeff_reg),
        .quat_coeff  (quat_coeff_reg),
        .cmd         (cmd),
        .status      (status),
        .out_word    (out_word)
    );

    assign accel_x = $signed(out_word[0]);
    assign accel_y = $signed(out_word[1]);
    assign accel_z = $signed(out_word[2]);
    assign rate_x  = $signed(out_word[3]);
    assign rate_y  = $signed(out_word[4]);
    assign rate_z  = $signed(out_word[5]);
    assign quat_w  = $signed(out_word[6]);
    assign quat_x  = $signed(out_word[7]);
    assign quat_y  = $signed(out_word[8]);
    assign quat_z  = $signed(out_word[9]);

`include "imu_frame_deframer_scaler_unit_assert.svh"

    `IFDS_ASSERT(a_pub_sum_ok, cmd.load_out |-> status.sum_ok, "publish with bad checksum")
    `IFDS_ASSERT(a_pub_no_clobber, cmd.load_out |-> !(out_valid && out_stall), "held result overwritten")
    `IFDS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid, "result valid during reset")

endmodule

/* tb/sv/tb_imu_frame_deframer_scaler_unit.sv */
// Self-checking testbench for imu_frame_deframer_scaler_unit: UART byte requests in,
// scaled IMU frames out, coefficients set over APB. Depends on ifds_pkg and the RTL top.
// Expected frames come from a behavioral deframer/scaler kept in step with accepted bytes.
module tb_imu_frame_deframer_scaler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ifds_pkg::*;

    localparam logic [1:0] REG_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 64;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_BYTES = 170;
    localparam int PHASE_GOOD = 5;

    typedef logic [15:0] raw_frame_t [WORD_COUNT];

    logic clk = 1'b0;
    logic rst_n;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] rx_byte = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] accel_x, accel_y, accel_z;
    logic signed [31:0] rate_x, rate_y, rate_z;
    logic signed [31:0] quat_w, quat_x, quat_y, quat_z;

    // predictor state
    logic [31:0] accel_k = ACCEL_COEFF_RST;
    logic [31:0] gyro_k = GYRO_COEFF_RST;
    logic [31:0] quat_k = QUAT_COEFF_RST;
    logic [7:0] frame_bytes [FRAME_LEN];
    int fill_level = 0;

    logic [7:0] pending_bytes [$];
    word_vec_t expected_frames [$];
    int queued_bytes = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit byte_taken = 1'b0;

    string field_names [WORD_COUNT] = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y",
                                        "rate_z", "quat_w", "quat_x", "quat_y", "quat_z"};

    imu_frame_deframer_scaler_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .accel_x(accel_x),
        .accel_y(accel_y),
        .accel_z(accel_z),
        .rate_x(rate_x),
        .rate_y(rate_y),
        .rate_z(rate_z),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // (raw * coeff + 2^23) >> 24, arithmetic
    function automatic logic [31:0] scale_q16(input logic [15:0] raw, input logic [31:0] coeff);
        longint prod;
        prod = longint'($signed(raw)) * longint'({32'd0, coeff}) + 64'sd8388608;
        return 32'(prod >>> 24);
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output word_vec_t words);
        logic [7:0] csum;
        logic [31:0] coeff;
        bit found;
        int k;
        int j;
        words = '0;
        if (fill_level == 0 && b != HEADER_BYTE)
            return 1'b0;
        if (fill_level >= FRAME_LEN)
            fill_level = 0;
        frame_bytes[fill_level] = b;
        fill_level++;
        if (fill_level < FRAME_LEN)
            return 1'b0;
        csum = 8'h00;
        for (k = 1; k <= 2 * WORD_COUNT; k++)
            csum = csum + frame_bytes[k];
        if (csum != frame_bytes[FRAME_LEN-1])
        begin
            // drop the header, slide to the next buffered 0x55
            found = 1'b0;
            for (k = 1; k < FRAME_LEN; k++)
            begin
                if (!found && frame_bytes[k] == HEADER_BYTE)
                begin
                    for (j = 0; j < FRAME_LEN - k; j++)
                        frame_bytes[j] = frame_bytes[j+k];
                    fill_level = FRAME_LEN - k;
                    found = 1'b1;
                end
            end
            if (!found)
                fill_level = 0;
            return 1'b0;
        end
        for (k = 0; k < WORD_COUNT; k++)
        begin
            coeff = (k < 3) ? accel_k : (k < 6) ? gyro_k : quat_k;
            words[k] = scale_q16({frame_bytes[2*k+2], frame_bytes[2*k+1]}, coeff);
        end
        fill_level = 0;
        return 1'b1;
    endfunction

    task automatic queue_frame(input raw_frame_t words, input logic [7:0] sum_err,
                               input int keep);
        logic [7:0] frame [FRAME_LEN];
        logic [7:0] csum;
        int k;
        csum = 8'h00;
        frame[0] = HEADER_BYTE;
        for (k = 0; k < WORD_COUNT; k++)
        begin
            frame[2*k+1] = words[k][7:0];
            frame[2*k+2] = words[k][15:8];
            csum = csum + words[k][7:0] + words[k][15:8];
        end
        frame[FRAME_LEN-1] = csum + sum_err;
        for (k = 0; k < keep; k++)
            pending_bytes.push_back(frame[k]);
        queued_bytes += keep;
    endtask

    task automatic queue_random_phase();
        raw_frame_t words;
        int start_bytes;
        int good;
        int pick;
        int k;
        start_bytes = queued_bytes;
        good = 0;
        while (queued_bytes - start_bytes < PHASE_BYTES || good < PHASE_GOOD)
        begin
            for (k = 0; k < WORD_COUNT; k++)
            begin
                if ($urandom_range(99) < 25)
                begin
                    case ($urandom_range(5))
                        0: words[k] = 16'h8000;
                        1: words[k] = 16'h7FFF;
                        2: words[k] = 16'hFFFF;
                        3: words[k] = 16'h0000;
                        4: words[k] = 16'h0001;
                        default: words[k] = 16'h8001;
                    endcase
                end
                else
                    words[k] = 16'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 64)
            begin
                queue_frame(words, 8'h00, FRAME_LEN);
                good++;
            end
            else if (pick < 82)
            begin
                // bad checksum, usually with a header buried in the payload
                if ($urandom_range(99) < 70)
                begin
                    k = $urandom_range(WORD_COUNT - 1);
                    if ($urandom_range(1))
                        words[k][15:8] = HEADER_BYTE;
                    else
                        words[k][7:0] = HEADER_BYTE;
                end
                queue_frame(words, 8'($urandom_range(255, 1)), FRAME_LEN);
            end
            else if (pick < 92)
                queue_frame(words, 8'h00, $urandom_range(FRAME_LEN - 1, 1));
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    pending_bytes.push_back(8'($urandom));
                    queued_bytes++;
                end
            end
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ACCEL: accel_k = value;
            REG_GYRO: gyro_k = value;
            REG_QUAT: quat_k = value;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_expect(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            report_mismatch($sformatf("register %0d read %h want %h", idx, got, want));
    endtask

    task automatic check_coeffs();
        apb_expect(REG_ACCEL, accel_k);
        apb_expect(REG_GYRO, gyro_k);
        apb_expect(REG_QUAT, quat_k);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin : byte_driver
        logic next_valid;
        logic [7:0] next_byte;
        next_valid = in_valid;
        next_byte = rx_byte;
        if (byte_taken)
        begin
            next_valid = 1'b0;
            byte_taken = 1'b0;
        end
        if (!next_valid && pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
        begin
            next_byte = pending_bytes.pop_front();
            next_valid = 1'b1;
        end
        in_valid <= next_valid;
        rx_byte <= next_byte;
    end

    always @(negedge clk)
    begin : stall_driver
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge clk)
    begin : byte_accept
        word_vec_t words;
        if (rst_n && in_valid && !in_stall)
        begin
            byte_taken = 1'b1;
            if (deframe_byte(rx_byte, words))
                expected_frames.push_back(words);
        end
    end

    always @(posedge clk)
    begin : frame_check
        word_vec_t got;
        word_vec_t want;
        int k;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {quat_z, quat_y, quat_x, quat_w, rate_z, rate_y, rate_x,
                   accel_z, accel_y, accel_x};
            if (expected_frames.size() == 0)
                report_mismatch("frame out with none expected");
            else
            begin
                want = expected_frames.pop_front();
                for (k = 0; k < WORD_COUNT; k++)
                begin
                    if (got[k] !== want[k])
                        report_mismatch($sformatf("%s got %h want %h",
                                                  field_names[k], got[k], want[k]));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("imu_frame_deframer_scaler_unit regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        raw_frame_t edge_words;
        logic [31:0] a, g, q;
        int ph;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_coeffs();

        // noise ahead of the header, then one frame of extreme words
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hAA);
        edge_words = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001,
                       16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
        queue_frame(edge_words, 8'h00, FRAME_LEN);
        wait_drained();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin a = '0; g = '0; q = '0; end
                1: begin a = '1; g = '1; q = '1; end
                2: begin a = $urandom; g = $urandom; q = $urandom; end
                3: begin a = '1; g = '0; q = $urandom; end
                default: begin a = ACCEL_COEFF_RST; g = GYRO_COEFF_RST; q = QUAT_COEFF_RST; end
            endcase
            apb_write(REG_ACCEL, a);
            apb_write(REG_GYRO, g);
            apb_write(REG_QUAT, q);
            apb_write(REG_NONE, $urandom);
            check_coeffs();
            case (ph)
                0: begin src_idle_pct = 74; sink_stall_pct = 0; end
                1: begin src_idle_pct = 0; sink_stall_pct = 74; end
                2: begin src_idle_pct = 29; sink_stall_pct = 29; end
                3: begin src_idle_pct = 0; sink_stall_pct = 0; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            queue_random_phase();
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("imu_frame_deframer_scaler_unit regression: pass");
        else
            $display("imu_frame_deframer_scaler_unit regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ifds_pkg.sv
rtl/ifds_ctrl.sv
rtl/ifds_dp.sv
rtl/imu_frame_deframer_scaler_unit.sv
tb/sv/tb_imu_frame_deframer_scaler_unit.sv
